// ===== design/polyline_miter_vertex_gen_macros.svh =====
// Assertion macros for the polyline miter vertex generator.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef POLYLINE_MITER_VERTEX_GEN_MACROS_SVH
`define POLYLINE_MITER_VERTEX_GEN_MACROS_SVH
`ifndef ASSERT_OFF
`define PMVG_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PMVG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PMVG_ASSERT_IMPL(label, ante, cons, msg)
`define PMVG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/pmvg_pkg.sv =====
// Shared constants and types for the polyline miter vertex generator.
// No dependencies.
package pmvg_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int NRM_BITS = 16;
	localparam int WID_BITS = 16;
	localparam int COL_BITS = 32;
	localparam int OFF_BITS = 24;
	localparam logic [OFF_BITS-1:0] OFF_MAX = 24'h7FFFFF;
	// square root of a sum of two 30-bit squares
	localparam int RAD_BITS = 62;
	localparam int ROOT_BITS = 31;
	localparam int SQ_REM_BITS = 33;
	// component division: quotient at most 16384
	localparam int NQ_BITS = 15;
	localparam int NDVD_BITS = 45;
	// miter division
	localparam int MQ_BITS = 24;
	localparam int MDVD_BITS = 49;
	localparam int MDVS_BITS = 30;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;
endpackage

// ===== design/pmvg_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
// Depends on pmvg_pkg.
module pmvg_sqrt import pmvg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_BITS-1:0]  rad,
	output logic [ROOT_BITS-1:0] root,
	output unit_stat_t           stat
);
	localparam int STEPS = RAD_BITS / 2;
	localparam int CNT_BITS = $clog2(STEPS + 1);

	logic [RAD_BITS-1:0]    rad_q;
	logic [SQ_REM_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   busy_q, done_q;
	logic [SQ_REM_BITS-1:0] rem_sh, trial;
	logic                   ge;

	always_comb begin
		rem_sh = {rem_q[SQ_REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_BITS-2:0], ge};
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

// ===== design/pmvg_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on pmvg_pkg.
module pmvg_div import pmvg_pkg::*; #(
	parameter int DVD_BITS = NDVD_BITS,
	parameter int DVS_BITS = ROOT_BITS,
	parameter int Q_BITS   = NQ_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DVS_BITS-1:0] divisor,
	output logic [Q_BITS-1:0]   quo,
	output logic                ovf,
	output unit_stat_t          stat
);
	localparam int CW = ((DVD_BITS > DVS_BITS + Q_BITS) ? DVD_BITS : DVS_BITS + Q_BITS) + 1;
	localparam int CNT_BITS = $clog2(Q_BITS + 1);

	logic [CW-1:0]       rem_q, dsh_q;
	logic [Q_BITS-1:0]   quo_q;
	logic                ovf_q, busy_q, done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(Q_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CW'(dividend);
			dsh_q <= CW'(divisor) << (Q_BITS - 1);
			ovf_q <= CW'(dividend) >= (CW'(divisor) << Q_BITS);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_BITS-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign ovf  = ovf_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

// ===== design/pmvg_norm.sv =====
// Vector normalizer to a Q1.14 unit vector: serial range shift, square,
// serial square root and serial divisions. Depends on pmvg_pkg, pmvg_sqrt, pmvg_div.
`include "polyline_miter_vertex_gen_macros.svh"
module pmvg_norm import pmvg_pkg::*; #(
	parameter int IN_BITS = COORD_BITS_DEF + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [IN_BITS-1:0]  vx,
	input  logic signed [IN_BITS-1:0]  vy,
	output logic signed [NRM_BITS-1:0] nx,
	output logic signed [NRM_BITS-1:0] ny,
	output unit_stat_t                 stat
);
	localparam int MW = (IN_BITS > 31) ? IN_BITS : 31;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_SHIFT = 4'd1, ST_SQX = 4'd2,
		ST_SQY = 4'd3, ST_ADD = 4'd4, ST_SQ_GO = 4'd5, ST_SQ_W = 4'd6,
		ST_DX_GO = 4'd7, ST_DX_W = 4'd8, ST_DY_GO = 4'd9, ST_DY_W = 4'd10,
		ST_FIN = 4'd11;

	logic [3:0]           state_q;
	logic                 done_q;
	logic                 sx_q, sy_q;
	logic [MW-1:0]        ax_q, ay_q, orv;
	logic [IN_BITS-1:0]   magx, magy;
	logic [59:0]          prod, prod_q;
	logic [RAD_BITS-1:0]  sum_q;
	logic [29:0]          mop;
	logic [ROOT_BITS-1:0] len_q, root;
	logic [NQ_BITS-1:0]   quo;
	logic [NDVD_BITS-1:0] dvd;
	logic                 dovf;
	logic signed [NRM_BITS-1:0] nx_q, ny_q, qs;
	unit_stat_t           sq_stat, dv_stat;

	assign magx = vx[IN_BITS-1] ? (~vx + 1'b1) : vx;
	assign magy = vy[IN_BITS-1] ? (~vy + 1'b1) : vy;
	assign orv  = ax_q | ay_q;
	assign mop  = (state_q == ST_SQX) ? ax_q[29:0] : ay_q[29:0];
	assign prod = mop * mop;
	assign dvd  = NDVD_BITS'({((state_q == ST_DX_GO) ? ax_q[29:0] : ay_q[29:0]), 14'b0})
		+ NDVD_BITS'(len_q[ROOT_BITS-1:1]);
	assign qs   = NRM_BITS'({1'b0, quo});

	pmvg_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_SQ_GO),
		.rad(sum_q), .root(root), .stat(sq_stat)
	);

	pmvg_div #(.DVD_BITS(NDVD_BITS), .DVS_BITS(ROOT_BITS), .Q_BITS(NQ_BITS)) u_div (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == ST_DX_GO || state_q == ST_DY_GO),
		.dividend(dvd), .divisor(len_q), .quo(quo), .ovf(dovf), .stat(dv_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) state_q <= (vx == '0 && vy == '0) ? ST_FIN : ST_SHIFT;
				ST_SHIFT: if (!(|orv[MW-1:30]) && orv[29]) state_q <= ST_SQX;
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_SQ_GO;
				ST_SQ_GO: state_q <= ST_SQ_W;
				ST_SQ_W: if (sq_stat.done) state_q <= ST_DX_GO;
				ST_DX_GO: state_q <= ST_DX_W;
				ST_DX_W: if (dv_stat.done) state_q <= ST_DY_GO;
				ST_DY_GO: state_q <= ST_DY_W;
				ST_DY_W: if (dv_stat.done) state_q <= ST_FIN;
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				sx_q <= vx[IN_BITS-1];
				sy_q <= vy[IN_BITS-1];
				ax_q <= MW'(magx);
				ay_q <= MW'(magy);
				nx_q <= '0;
				ny_q <= '0;
			end
			ST_SHIFT: begin
				// bring the larger magnitude into [2^29, 2^30)
				if (|orv[MW-1:30]) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (!orv[29]) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			ST_SQX: prod_q <= prod;
			ST_SQY: begin
				prod_q <= prod;
				sum_q  <= RAD_BITS'(prod_q);
			end
			ST_ADD: sum_q <= sum_q + RAD_BITS'(prod_q);
			ST_SQ_W: if (sq_stat.done) len_q <= root;
			ST_DX_W: if (dv_stat.done) nx_q <= sx_q ? -qs : qs;
			ST_DY_W: if (dv_stat.done) ny_q <= sy_q ? -qs : qs;
			default: ;
		endcase
	end

	assign nx   = nx_q;
	assign ny   = ny_q;
	assign stat = '{busy: (state_q != ST_IDLE), done: done_q};

	// a component never exceeds the length, so the quotient fits
	`PMVG_ASSERT_IMPL(a_comp_no_ovf, dv_stat.done, !dovf,
		"component division overflowed")
	`PMVG_ASSERT_IMPL(a_start_idle, start, state_q == ST_IDLE,
		"normalizer started while busy")
	`PMVG_ASSERT_NEXT(a_done_pulse, done_q, !done_q,
		"done held for more than one cycle")
endmodule

// ===== design/polyline_miter_vertex_gen.sv =====
// Top level of the polyline miter vertex generator: sequencer, point state,
// miter divider and output register. Depends on pmvg_pkg, pmvg_norm, pmvg_div.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid, in_stall | point_x, point_y, width, color, last
//  out     | out_valid,out_stall| vert_x, vert_y, normal_x, normal_y, offset,
//          |                    | vert_color, end_of_run
//
// One point at a time. The first point of a run only updates the point state;
// later points run normalizations, whose time is set by the range shift, the
// bit-serial square root (31 steps) and the bit-serial dividers (15 steps per
// component, 24 for the miter), and wait on output stalls; an interior point runs
// two normalizations and, unless the width is zero or the dot product is not positive, the miter division.
// Results leave through one output register; while it is stalled the
// sequencer holds. in_stall is high while a point is in work.
// Reset clears the point state and the run counter.
`include "polyline_miter_vertex_gen_macros.svh"
module polyline_miter_vertex_gen import pmvg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic [WID_BITS-1:0]          width,
	input  logic [COL_BITS-1:0]          color,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] vert_x,
	output logic signed [COORD_BITS-1:0] vert_y,
	output logic signed [NRM_BITS-1:0]   normal_x,
	output logic signed [NRM_BITS-1:0]   normal_y,
	output logic signed [OFF_BITS-1:0]   offset,
	output logic [COL_BITS-1:0]          vert_color,
	output logic                         end_of_run
);
	localparam int NW = COORD_BITS + 1;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_N1_GO = 4'd1, ST_N1_W = 4'd2,
		ST_N2_GO = 4'd3, ST_N2_W = 4'd4, ST_DOT1 = 4'd5, ST_DOT2 = 4'd6,
		ST_MIT_CHK = 4'd7, ST_MIT_GO = 4'd8, ST_MIT_W = 4'd9, ST_EMIT = 4'd10,
		ST_UPD = 4'd11;

	logic [3:0] state_q;
	logic [1:0] points_q, e_q;

	logic signed [COORD_BITS-1:0] px_q, py_q, cx_q, cy_q;
	logic [WID_BITS-1:0]          pw_q, cw_q;
	logic [COL_BITS-1:0]          pc_q, cc_q;
	logic                         clast_q;
	logic signed [NRM_BITS-1:0]   pdx_q, pdy_q, dx_q, dy_q, n0x_q, n0y_q;
	logic [OFF_BITS-1:0]          off0_q;
	logic signed [31:0]           dp_q, d_q, prod;
	logic signed [NRM_BITS-1:0]   mul_a, mul_b;

	logic                         norm_start;
	logic signed [NW-1:0]         nvx, nvy;
	logic signed [NRM_BITS-1:0]   norm_nx, norm_ny;
	unit_stat_t                   norm_stat, div_stat;
	logic [MDVD_BITS-1:0]         mdvd;
	logic [MQ_BITS-1:0]           mquo;
	logic                         movf;

	logic                         out_valid_q, emit_go, e_last;
	logic [OFF_BITS-1:0]          e_off;

	assign in_stall   = (state_q != ST_IDLE);
	assign norm_start = (state_q == ST_N1_GO) || (state_q == ST_N2_GO);

	always_comb begin
		if (state_q == ST_N1_GO) begin
			nvx = NW'(cx_q) - NW'(px_q);
			nvy = NW'(cy_q) - NW'(py_q);
		end else begin
			nvx = NW'(pdx_q) + NW'(dx_q);
			nvy = NW'(pdy_q) + NW'(dy_q);
		end
	end

	pmvg_norm #(.IN_BITS(NW)) u_norm (
		.clk(clk), .arst_n(arst_n), .start(norm_start), .vx(nvx), .vy(nvy),
		.nx(norm_nx), .ny(norm_ny), .stat(norm_stat)
	);

	// dot product of miter and incoming normal, one multiply per cycle
	assign mul_a = (state_q == ST_DOT1) ? n0x_q : n0y_q;
	assign mul_b = (state_q == ST_DOT1) ? -pdy_q : pdx_q;
	assign prod  = mul_a * mul_b;

	assign mdvd = {1'b0, pw_q, 32'b0} + MDVD_BITS'(d_q[31:1]);

	pmvg_div #(.DVD_BITS(MDVD_BITS), .DVS_BITS(MDVS_BITS), .Q_BITS(MQ_BITS)) u_mdiv (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_MIT_GO),
		.dividend(mdvd), .divisor(d_q[MDVS_BITS-1:0]), .quo(mquo), .ovf(movf),
		.stat(div_stat)
	);

	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign e_last  = (e_q == (clast_q ? 2'd3 : 2'd1));
	assign e_off   = e_q[1] ? {4'b0, cw_q, 4'b0} : off0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			points_q    <= 2'd0;
			e_q         <= 2'd0;
			out_valid_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			pw_q        <= '0;
			pc_q        <= '0;
			pdx_q       <= '0;
			pdy_q       <= '0;
		end else begin
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= (points_q == 2'd0) ? ST_UPD : ST_N1_GO;
				ST_N1_GO: state_q <= ST_N1_W;
				ST_N1_W: if (norm_stat.done) begin
					e_q     <= 2'd0;
					state_q <= (points_q == 2'd1) ? ST_EMIT : ST_N2_GO;
				end
				ST_N2_GO: state_q <= ST_N2_W;
				ST_N2_W: if (norm_stat.done) state_q <= ST_DOT1;
				ST_DOT1: state_q <= ST_DOT2;
				ST_DOT2: state_q <= ST_MIT_CHK;
				ST_MIT_CHK: begin
					if (pw_q == '0 || d_q[31] || d_q == '0)
						state_q <= ST_EMIT;
					else
						state_q <= ST_MIT_GO;
				end
				ST_MIT_GO: state_q <= ST_MIT_W;
				ST_MIT_W: if (div_stat.done) state_q <= ST_EMIT;
				ST_EMIT: if (emit_go) begin
					if (e_last)
						state_q <= ST_UPD;
					else
						e_q <= e_q + 1'b1;
				end
				ST_UPD: begin
					px_q  <= cx_q;
					py_q  <= cy_q;
					pw_q  <= cw_q;
					pc_q  <= cc_q;
					pdx_q <= dx_q;
					pdy_q <= dy_q;
					if (clast_q)
						points_q <= 2'd0;
					else if (points_q != 2'd2)
						points_q <= points_q + 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_valid) begin
				cx_q    <= point_x;
				cy_q    <= point_y;
				cw_q    <= width;
				cc_q    <= color;
				clast_q <= last;
				dx_q    <= '0;
				dy_q    <= '0;
			end
			ST_N1_W: if (norm_stat.done) begin
				dx_q   <= norm_nx;
				dy_q   <= norm_ny;
				n0x_q  <= -norm_ny;
				n0y_q  <= norm_nx;
				off0_q <= {4'b0, pw_q, 4'b0};
			end
			ST_N2_W: if (norm_stat.done) begin
				n0x_q <= -norm_ny;
				n0y_q <= norm_nx;
			end
			ST_DOT1: dp_q <= prod;
			ST_DOT2: d_q <= dp_q + prod;
			ST_MIT_CHK: begin
				if (pw_q == '0)
					off0_q <= '0;
				else
					off0_q <= OFF_MAX;
			end
			ST_MIT_W: if (div_stat.done)
				off0_q <= (movf || mquo[MQ_BITS-1]) ? OFF_MAX : mquo;
			default: ;
		endcase
	end

	// output register: first pair at the previous point, second (last point of a run only) at this one
	always_ff @(posedge clk) begin
		if (emit_go) begin
			vert_x     <= e_q[1] ? cx_q : px_q;
			vert_y     <= e_q[1] ? cy_q : py_q;
			normal_x   <= e_q[1] ? -dy_q : n0x_q;
			normal_y   <= e_q[1] ? dx_q : n0y_q;
			offset     <= e_q[0] ? -e_off : e_off;
			vert_color <= e_q[1] ? cc_q : pc_q;
			end_of_run <= e_last;
		end
	end

	assign out_valid = out_valid_q;

	`PMVG_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != ST_IDLE,
		"accepted item left the sequencer idle")
	`PMVG_ASSERT_NEXT(a_eor_update, emit_go && e_last, state_q == ST_UPD,
		"final result not followed by state update")
	`PMVG_ASSERT_IMPL(a_points_range, 1'b1, points_q != 2'd3,
		"run counter beyond two")
	`PMVG_ASSERT_IMPL(a_norm_free, norm_start, !norm_stat.busy,
		"normalizer started while busy")
endmodule

// ===== test/tb_polyline_miter_vertex_gen.sv =====
// Self-checking testbench for polyline_miter_vertex_gen: drives polyline points
// with bursty valid and random output stall, predicts the extruded vertices.
// Depends on pmvg_pkg and the polyline_miter_vertex_gen RTL.
`timescale 1ns / 1ps
module tb_polyline_miter_vertex_gen;
	import pmvg_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic [WID_BITS-1:0]  w;
		logic [COL_BITS-1:0]  c;
		logic                 last;
	} point_t;

	typedef struct {
		logic [CB-1:0]       x;
		logic [CB-1:0]       y;
		logic [NRM_BITS-1:0] nx;
		logic [NRM_BITS-1:0] ny;
		logic [OFF_BITS-1:0] off;
		logic [COL_BITS-1:0] c;
		logic                eor;
	} vertex_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CB-1:0] point_x = 0;
	logic signed [CB-1:0] point_y = 0;
	logic [WID_BITS-1:0] width = 0;
	logic [COL_BITS-1:0] color = 0;
	logic last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [CB-1:0] vert_x;
	logic signed [CB-1:0] vert_y;
	logic signed [NRM_BITS-1:0] normal_x;
	logic signed [NRM_BITS-1:0] normal_y;
	logic signed [OFF_BITS-1:0] offset;
	logic [COL_BITS-1:0] vert_color;
	logic end_of_run;

	polyline_miter_vertex_gen DUT (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	point_t point_queue[$];
	vertex_t pending_verts[$];
	int errors = 0;
	int idle_cycles = 0;

	// predictor copy of the point state
	longint prv_x, prv_y;
	longint unsigned prv_w, prv_c;
	int prv_dx, prv_dy;
	int seen;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void unit_vec(input longint x, input longint y, output int nx,
			output int ny);
		longint unsigned ax, ay, len, qx, qy;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		if ((ax | ay) == 0) begin
			nx = 0;
			ny = 0;
			return;
		end
		while ((ax | ay) >= (64'h1 << 30)) begin
			ax >>= 1;
			ay >>= 1;
		end
		while ((ax | ay) < (64'h1 << 29)) begin
			ax <<= 1;
			ay <<= 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		qx = (ax * 16384 + len / 2) / len;
		qy = (ay * 16384 + len / 2) / len;
		nx = x < 0 ? -int'(qx) : int'(qx);
		ny = y < 0 ? -int'(qy) : int'(qy);
	endfunction

	function automatic longint miter_len(input longint unsigned w, input int mx, input int my,
			input int nx, input int ny);
		longint d;
		longint unsigned q;
		d = longint'(mx) * nx + longint'(my) * ny;
		if (w == 0) return 0;
		if (d <= 0) return OFF_MAX;
		q = ((w << 32) + longint'(unsigned'(d)) / 2) / longint'(unsigned'(d));
		return q > OFF_MAX ? longint'(OFF_MAX) : longint'(q);
	endfunction

	task automatic push_pair(input longint x, input longint y, input int nx, input int ny,
			input longint off, input longint unsigned c);
		vertex_t v;
		v.x = x[CB-1:0];
		v.y = y[CB-1:0];
		v.nx = nx[NRM_BITS-1:0];
		v.ny = ny[NRM_BITS-1:0];
		v.off = off[OFF_BITS-1:0];
		v.c = c[COL_BITS-1:0];
		v.eor = 0;
		pending_verts.insert(pending_verts.size(), v);
		off = -off;
		v.off = off[OFF_BITS-1:0];
		pending_verts.insert(pending_verts.size(), v);
	endtask

	task automatic predict_point(input point_t p);
		longint cx, cy;
		int dx, dy, tx, ty;
		cx = longint'(p.x);
		cy = longint'(p.y);
		dx = 0;
		dy = 0;
		if (seen != 0) begin
			unit_vec(cx - prv_x, cy - prv_y, dx, dy);
			if (seen == 1)
				push_pair(prv_x, prv_y, -dy, dx, prv_w << 4, prv_c);
			else begin
				unit_vec(longint'(prv_dx) + dx, longint'(prv_dy) + dy, tx, ty);
				push_pair(prv_x, prv_y, -ty, tx,
					miter_len(prv_w, -ty, tx, -prv_dy, prv_dx), prv_c);
			end
			if (p.last)
				push_pair(cx, cy, -dy, dx, longint'(p.w) << 4, p.c);
			pending_verts[pending_verts.size() - 1].eor = 1;
		end
		prv_x = cx;
		prv_y = cy;
		prv_w = p.w;
		prv_c = p.c;
		prv_dx = dx;
		prv_dy = dy;
		if (p.last) seen = 0;
		else if (seen < 2) seen++;
	endtask

	// driver: bursts of items separated by random gaps
	point_t cur_pt;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			seen = 0;
			prv_x = 0;
			prv_y = 0;
			prv_w = 0;
			prv_c = 0;
			prv_dx = 0;
			prv_dy = 0;
		end else begin
			if (in_valid && !in_stall) predict_point(cur_pt);
			// hold a stalled item
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 0;
				end else if (point_queue.size() > 0) begin
					cur_pt = point_queue.pop_front();
					point_x <= cur_pt.x;
					point_y <= cur_pt.y;
					width <= cur_pt.w;
					color <= cur_pt.c;
					last <= cur_pt.last;
					in_valid <= 1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
					end else
						burst_left--;
				end else
					in_valid <= 0;
			end
		end
	end

	// monitor: stall on a pattern of its own, check each accepted vertex
	int stall_mode = 0;
	int mode_left = 0;

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_verts.size() == 0)
					report("vertex with nothing expected");
				else begin
					e = pending_verts.pop_front();
					check_field("vert_x", 32'(unsigned'(vert_x)), 32'(e.x));
					check_field("vert_y", 32'(unsigned'(vert_y)), 32'(e.y));
					check_field("normal_x", 32'(unsigned'(normal_x)), 32'(e.nx));
					check_field("normal_y", 32'(unsigned'(normal_y)), 32'(e.ny));
					check_field("offset", 32'(unsigned'(offset)), 32'(e.off));
					check_field("vert_color", vert_color, e.c);
					check_field("end_of_run", 32'(end_of_run), 32'(e.eor));
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				idle_cycles = 0;
			else if (++idle_cycles >= IDLE_LIMIT) begin
				$display("tb_polyline_miter_vertex_gen NOT OK");
				$finish;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 300);
				stall_mode = $urandom_range(0, 2);
			end else
				mode_left--;
			case (stall_mode)
				0: out_stall <= 0;
				1: out_stall <= $urandom_range(0, 2) == 0;
				default: out_stall <= $urandom_range(0, 7) != 0;
			endcase
		end
	end

	task automatic add_pt(input longint x, input longint y, input int w,
			input logic [31:0] c, input bit lst);
		point_t p;
		p.x = x[CB-1:0];
		p.y = y[CB-1:0];
		p.w = w[WID_BITS-1:0];
		p.c = c;
		p.last = lst;
		point_queue.insert(point_queue.size(), p);
	endtask

	function automatic int rnd_width();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 16'hFFFF;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	initial begin
		longint x, y, dx, dy;
		int n, run_len, step_kind;
		// directed: single-point run, extremes, repeated point, reversal, sharp turn
		add_pt(100, 200, 300, 32'h11223344, 1);
		add_pt(-8388608, -8388608, 0, 32'h00000000, 0);
		add_pt(8388607, 8388607, 16'hFFFF, 32'hFFFFFFFF, 1);
		add_pt(0, 0, 256, 32'hA5A5A5A5, 0);
		add_pt(4096, 0, 16'hFFFF, 32'h5A5A5A5A, 0);
		add_pt(4096, 0, 512, 32'h01020304, 0);
		add_pt(8192, 4096, 0, 32'h05060708, 0);
		add_pt(4096, 0, 1024, 32'h090A0B0C, 0);
		add_pt(8192, 4096, 16'hFFFF, 32'h0D0E0F10, 0);
		add_pt(12288, 4000, 16'hFFFF, 32'h11121314, 0);
		add_pt(0, 4100, 200, 32'h15161718, 0);
		add_pt(8388607, -8388608, 16'h8000, 32'h80000000, 0);
		add_pt(-8388608, 8388607, 1, 32'h7FFFFFFF, 1);
		add_pt(5, 5, 10, 32'hDEADBEEF, 0);
		add_pt(5, 5, 20, 32'hCAFEF00D, 1);
		add_pt(-1, -1, 16'hFFFF, 32'hFFFFFFFF, 0);
		add_pt(-1, 4096, 16'hFFFF, 32'h0, 0);
		add_pt(4095, 4096, 16'hFFFF, 32'h0, 1);

		n = 0;
		while (n < 320) begin
			run_len = $urandom_range(1, 8);
			x = $urandom_range(0, 3) == 0 ? longint'($signed($urandom)) >>> 8
				: longint'($urandom_range(0, 65536)) - 32768;
			y = $urandom_range(0, 3) == 0 ? longint'($signed($urandom)) >>> 8
				: longint'($urandom_range(0, 65536)) - 32768;
			dx = 4096;
			dy = 0;
			for (int i = 0; i < run_len; i++) begin
				add_pt(x, y, rnd_width(), $urandom, i == run_len - 1);
				n++;
				step_kind = $urandom_range(0, 19);
				if (step_kind == 0) begin
					dx = 0;
					dy = 0;
				end else if (step_kind == 1) begin
					dx = -dx;
					dy = -dy;
				end else if (step_kind == 2) begin
					dx = (longint'($signed($urandom)) >>> 8) - x;
					dy = (longint'($signed($urandom)) >>> 8) - y;
				end else if (step_kind < 6) begin
					dx = longint'($urandom_range(0, 64)) - 32;
					dy = longint'($urandom_range(0, 64)) - 32;
				end else begin
					dx = longint'($urandom_range(0, 40000)) - 20000;
					dy = longint'($urandom_range(0, 40000)) - 20000;
				end
				x += dx;
				y += dy;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1;
		while (point_queue.size() > 0 || in_valid || pending_verts.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_verts.size() > 0)
			report($sformatf("%0d vertices never arrived", pending_verts.size()));
		if (errors == 0)
			$display("tb_polyline_miter_vertex_gen OK");
		else
			$display("tb_polyline_miter_vertex_gen NOT OK");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/pmvg_pkg.sv
design/pmvg_sqrt.sv
design/pmvg_div.sv
design/pmvg_norm.sv
design/polyline_miter_vertex_gen.sv
test/tb_polyline_miter_vertex_gen.sv
